FILE: rtl/mma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI message assembler package
// Shared constants, the result type and the data-length decode.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int LANE_BITS = 8;
  localparam int MSG_BITS  = 3 * LANE_BITS;

  localparam logic [LANE_BITS-1:0] SYSEX_OPEN  = 8'hF0;
  localparam logic [LANE_BITS-1:0] SYSEX_CLOSE = 8'hF7;

  typedef struct packed {
    logic                valid;
    logic [MSG_BITS-1:0] message;
    logic [1:0]          data_count;
  } res_t;

  function automatic logic [1:0] expected_data(input logic [LANE_BITS-1:0] status);
    logic [1:0] n;
    n = 2'd0;
    case (status[7:4]) inside
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
      4'hC, 4'hD:                   n = 2'd1;
      4'hF: begin
        case (status[3:0]) inside
          4'h1, 4'h3: n = 2'd1;
          4'h2:       n = 2'd2;
          default:    n = 2'd0;
        endcase
      end
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mma_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI message assembler core
// Input register, parser state and the per-byte update logic.
// ----------------------------------------------------------------------------
module mma_core
  import mma_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [LANE_BITS-1:0] midi_byte,
  input  wire logic                 free,
  output res_t                      res
);

  logic                 ivalid;
  logic [LANE_BITS-1:0] ibyte;
  logic                 process;

  logic                in_sysex,  in_sysex_next;
  logic [MSG_BITS-1:0] assembled, assembled_next;
  logic [1:0]          byte_offset, byte_offset_next;
  logic [1:0]          bytes_left,  bytes_left_next;

  assign in_stall = ivalid && !free;
  assign process  = ivalid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (!in_stall) begin
      ivalid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      ibyte <= midi_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sysex    <= 1'b0;
      assembled   <= '0;
      byte_offset <= 2'd0;
      bytes_left  <= 2'd0;
    end else if (process) begin
      in_sysex    <= in_sysex_next;
      assembled   <= assembled_next;
      byte_offset <= byte_offset_next;
      bytes_left  <= bytes_left_next;
    end
  end

  always_comb begin
    in_sysex_next    = in_sysex;
    assembled_next   = assembled;
    byte_offset_next = byte_offset;
    bytes_left_next  = bytes_left;
    res.valid        = 1'b0;
    res.data_count   = 2'd0;
    if (in_sysex) begin
      if (ibyte == SYSEX_CLOSE) begin
        in_sysex_next = 1'b0;
      end
    end else if (ibyte == SYSEX_OPEN) begin
      in_sysex_next = 1'b1;
    end else if (!ibyte[7]) begin
      if (bytes_left != 2'd0) begin
        case (byte_offset)
          2'd0:    assembled_next[7:0]   = assembled[7:0]   | ibyte;
          2'd1:    assembled_next[15:8]  = assembled[15:8]  | ibyte;
          2'd2:    assembled_next[23:16] = assembled[23:16] | ibyte;
          default: assembled_next        = assembled;
        endcase
        byte_offset_next = byte_offset + 2'd1;
        bytes_left_next  = bytes_left - 2'd1;
        if (bytes_left_next == 2'd0) begin
          res.valid      = ivalid;
          res.data_count = byte_offset_next - 2'd1;
        end
      end
    end else begin
      assembled_next   = {{(MSG_BITS-LANE_BITS){1'b0}}, ibyte};
      byte_offset_next = 2'd1;
      bytes_left_next  = expected_data(ibyte);
      if (bytes_left_next == 2'd0) begin
        res.valid      = ivalid;
        res.data_count = 2'd0;
      end
    end
    res.message = assembled_next;
  end

  a_left_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left != 2'd3)
    else $error("bytes_left out of range");

  a_offset_lane: assert property (@(posedge clk) disable iff (rst)
    (bytes_left != 2'd0) |-> (byte_offset == 2'd1 || byte_offset == 2'd2))
    else $error("data lane out of range while data expected");

  a_sysex_quiet: assert property (@(posedge clk) disable iff (rst)
    (ivalid && in_sysex) |-> !res.valid)
    else $error("result raised inside SysEx");

endmodule

`default_nettype wire

FILE: rtl/mma_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI message assembler result register
// Holds one finished message until the receiving side takes it.
// ----------------------------------------------------------------------------
module mma_out
  import mma_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  res_t                     res,
  output logic                     free,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [MSG_BITS-1:0]      message,
  output logic [1:0]               data_count
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= res.valid;
    end
    if (free && res.valid) begin
      message    <= res.message;
      data_count <= res.data_count;
    end
  end

  a_load: assert property (@(posedge clk) disable iff (rst)
    (free && res.valid) |=> out_valid)
    else $error("result lost");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    (free && !res.valid) |=> !out_valid)
    else $error("result invented");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> data_count != 2'd3)
    else $error("data_count out of range");

endmodule

`default_nettype wire

FILE: rtl/midi_message_assembler.sv
// A byte taken into the input register has its message loaded into the result
//   register once the result register is free, not holding a stalled result.
// Throughput: one byte per cycle; the input register and the result register
//   each take a new item in every cycle the output side does not stall.
// Bytes that finish no message (data, SysEx) produce no result.
// Reset (rst, synchronous): leaves SysEx, clears the partial message and
//   both registers empty.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI message assembler
// Builds complete MIDI messages from a byte stream, one byte per item.
// ----------------------------------------------------------------------------
module midi_message_assembler
  import mma_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [LANE_BITS-1:0] midi_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [MSG_BITS-1:0]       message,
  output logic [1:0]                data_count
);

  res_t res;
  logic free;

  mma_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .midi_byte (midi_byte),
    .free      (free),
    .res       (res)
  );

  mma_out u_out (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .free       (free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .message    (message),
    .data_count (data_count)
  );

endmodule

`default_nettype wire

FILE: bench/midi_message_assembler_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message assembler checker
// Watches both channels of the assembler, rebuilds the expected messages from
// the accepted bytes and compares every accepted message field by field.
// ----------------------------------------------------------------------------
module midi_message_assembler_chk
  import mma_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [LANE_BITS-1:0] midi_byte,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [MSG_BITS-1:0]  message,
  input  wire logic [1:0]           data_count,
  output int                        fail_count,
  output int                        pending
);

  localparam logic [LANE_BITS-1:0] STATUS_MIN    = 8'h80;
  localparam logic [LANE_BITS-1:0] PROG_CHANGE   = 8'hC0;
  localparam logic [LANE_BITS-1:0] CHAN_PRESSURE = 8'hD0;
  localparam logic [LANE_BITS-1:0] TIME_CODE     = 8'hF1;
  localparam logic [LANE_BITS-1:0] SONG_POS      = 8'hF2;
  localparam logic [LANE_BITS-1:0] SONG_SEL      = 8'hF3;

  typedef struct packed {
    logic [MSG_BITS-1:0] message;
    logic [1:0]          data_count;
  } midi_msg_t;

  midi_msg_t               msg_q[$];
  logic                    in_sysex;
  logic [MSG_BITS-1:0]     partial_msg;
  logic [1:0]              lane;
  logic [1:0]              bytes_due;
  int                      fails  = 0;
  int                      queued = 0;

  assign fail_count = fails;
  assign pending    = queued;

  function automatic logic [1:0] data_len(input logic [LANE_BITS-1:0] status);
    if (status[7:4] == PROG_CHANGE[7:4] || status[7:4] == CHAN_PRESSURE[7:4]) return 2'd1;
    if (status[7:4] != SYSEX_OPEN[7:4]) return 2'd2;
    if (status == TIME_CODE || status == SONG_SEL) return 2'd1;
    if (status == SONG_POS) return 2'd2;
    return 2'd0;
  endfunction

  task automatic assemble_byte(input logic [LANE_BITS-1:0] b);
    logic [31:0] shifted;
    midi_msg_t   done;
    if (in_sysex) begin
      if (b == SYSEX_CLOSE) in_sysex = 1'b0;
    end else if (b == SYSEX_OPEN) begin
      in_sysex = 1'b1;
    end else if (b < STATUS_MIN) begin
      if (bytes_due != 2'd0) begin
        shifted     = {24'd0, b} << (LANE_BITS * lane);
        partial_msg = partial_msg | shifted[MSG_BITS-1:0];
        lane        = lane + 2'd1;
        bytes_due   = bytes_due - 2'd1;
        if (bytes_due == 2'd0) begin
          done.message    = partial_msg;
          done.data_count = lane - 2'd1;
          msg_q.push_back(done);
        end
      end
    end else begin
      partial_msg = {16'd0, b};
      lane        = 2'd1;
      bytes_due   = data_len(b);
      if (bytes_due == 2'd0) begin
        done.message    = partial_msg;
        done.data_count = 2'd0;
        msg_q.push_back(done);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    midi_msg_t want;
    if (rst) begin
      in_sysex    = 1'b0;
      partial_msg = '0;
      lane        = 2'd0;
      bytes_due   = 2'd0;
      msg_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (msg_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected message %06h data_count %0d, none expected",
                   $time, message, data_count);
        end else begin
          want = msg_q.pop_front();
          if (want.message !== message) begin
            fails++;
            $display("%0t: message expected %06h, got %06h", $time, want.message, message);
          end
          if (want.data_count !== data_count) begin
            fails++;
            $display("%0t: data_count expected %0d, got %0d",
                     $time, want.data_count, data_count);
          end
        end
      end
      if (in_valid && !in_stall) assemble_byte(midi_byte);
    end
    queued = msg_q.size();
  end

endmodule

FILE: bench/midi_message_assembler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message assembler testbench
// Feeds directed and random MIDI byte streams in bursts against a stalling
// receiver, with one long hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module midi_message_assembler_tb
  import mma_pkg::*;
();

  localparam int ITEM_TARGET = 1400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 2000;

  localparam logic [LANE_BITS-1:0] NOTE_OFF       = 8'h80;
  localparam logic [LANE_BITS-1:0] NOTE_ON        = 8'h90;
  localparam logic [LANE_BITS-1:0] POLY_PRESSURE  = 8'hA0;
  localparam logic [LANE_BITS-1:0] CTRL_CHANGE    = 8'hB0;
  localparam logic [LANE_BITS-1:0] PROG_CHANGE    = 8'hC0;
  localparam logic [LANE_BITS-1:0] PITCH_BEND     = 8'hE0;
  localparam logic [LANE_BITS-1:0] CHAN_LAST      = 8'hEF;
  localparam logic [LANE_BITS-1:0] TIME_CODE      = 8'hF1;
  localparam logic [LANE_BITS-1:0] SONG_POS       = 8'hF2;
  localparam logic [LANE_BITS-1:0] FIRST_ZERO_LEN = 8'hF4;
  localparam logic [LANE_BITS-1:0] TIMING_CLOCK   = 8'hF8;
  localparam logic [LANE_BITS-1:0] ACTIVE_SENSE   = 8'hFE;
  localparam logic [LANE_BITS-1:0] SYS_RESET      = 8'hFF;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic [LANE_BITS-1:0] midi_byte = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [MSG_BITS-1:0]  message;
  logic [1:0]           data_count;
  int                   fail_count;
  int                   pending;
  int                   cycles     = 0;
  int                   burst_left = 0;
  int                   counted    = 0;
  stall_mode_t          stall_mode = STALL_HOLD;
  int                   phase_left = 0;

  logic [LANE_BITS-1:0] directed_bytes [0:25] = '{
    8'h33,
    NOTE_ON, 8'h00, 8'h7F,
    PROG_CHANGE | 8'h0F, 8'h40,
    SONG_POS, 8'h7F, 8'h00,
    TIME_CODE, 8'h2A,
    TIMING_CLOCK,
    SYSEX_CLOSE,
    CTRL_CHANGE, 8'h10, SYS_RESET,
    POLY_PRESSURE, 8'h11, SYSEX_OPEN, NOTE_OFF, ACTIVE_SENSE, SYSEX_CLOSE, 8'h22,
    PITCH_BEND | 8'h03, 8'h7F, 8'h7F
  };

  midi_message_assembler i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .midi_byte  (midi_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .message    (message),
    .data_count (data_count)
  );

  midi_message_assembler_chk i_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .midi_byte  (midi_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .message    (message),
    .data_count (data_count),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("midi_message_assembler_tb: FAIL");
      $finish;
    end
  end

  // open with a long hold so the block fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= STALL_HOLD;
      phase_left <= 300;
    end else begin
      if (phase_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        phase_left <= $urandom_range(20, 200);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'b1;
      endcase
    end
  end

  task automatic send_byte(input logic [LANE_BITS-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    midi_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_counted(input logic [LANE_BITS-1:0] b);
    send_byte(b);
    counted++;
  endtask

  function automatic logic [LANE_BITS-1:0] rand_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'h7F;
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic send_msg(input bit cut);
    logic [LANE_BITS-1:0] status;
    int                   len;
    int                   n;
    int                   pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      status = 8'($urandom_range(NOTE_OFF, CHAN_LAST));
      len    = (status >= PROG_CHANGE && status < PITCH_BEND) ? 1 : 2;
    end else if (pick == 7) begin
      status = 8'(TIME_CODE + $urandom_range(0, 2));
      len    = (status == SONG_POS) ? 2 : 1;
    end else begin
      status = 8'(FIRST_ZERO_LEN + $urandom_range(0, 11));
      len    = 0;
    end
    n = (cut && len > 0) ? $urandom_range(0, len - 1) : len;
    send_counted(status);
    repeat (n) send_counted(rand_data());
  endtask

  // optionally split a message with two data bytes around the SysEx block
  task automatic send_sysex();
    logic [LANE_BITS-1:0] b;
    bit                   split;
    split = $urandom_range(0, 1);
    if (split) begin
      send_counted(8'($urandom_range(NOTE_OFF, PROG_CHANGE - 1)));
      send_counted(rand_data());
    end
    send_counted(SYSEX_OPEN);
    repeat ($urandom_range(0, 8)) begin
      do b = 8'($urandom); while (b == SYSEX_CLOSE);
      send_counted(b);
    end
    send_counted(SYSEX_CLOSE);
    if (split) send_counted(rand_data());
  endtask

  initial begin : stimulus
    int drain;
    int pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_bytes[i]) send_counted(directed_bytes[i]);
    while (counted < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) send_msg(1'b0);
      else if (pick < 15) send_msg(1'b1);
      else if (pick < 17) send_sysex();
      else send_counted(8'($urandom));
    end
    in_valid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("midi_message_assembler_tb: PASS");
    end else begin
      if (pending != 0) $display("%0t: %0d expected messages never arrived", $time, pending);
      $display("midi_message_assembler_tb: FAIL");
    end
    $finish;
  end

endmodule
